### rtl/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared widths, register indexes and operation codes of the fractional
// delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int DEPTH       = 4096;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int DELAY_BITS  = 28;
  localparam int WHOLE_BITS  = DELAY_BITS - FRAC_BITS;
  localparam int FUNC_BITS   = 3;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [DELAY_BITS-1:0] ONE_SAMPLE    = DELAY_BITS'(1) << FRAC_BITS;
  localparam logic [DELAY_BITS-1:0] MAX_DELAY_RST = DELAY_BITS'(268304384);

  localparam logic [FUNC_BITS-1:0] FUNC_PROCESS  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_PUSH     = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_READ_CFG = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_READ_FB  = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_READ_CUR = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_SETTING = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DELAY     = 1'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [DELAY_BITS-1:0]         delay_t;
  typedef logic [FRAC_BITS-1:0]          frac_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;

  typedef struct packed {
    logic    has_result;
    logic    zero;
    logic    newer_smp;
    logic    older_smp;
    sample_t sample;
    frac_t   frac;
  } rd_ctl_t;

endpackage

### rtl/fdl_in_if.sv
// ----------------------------------------------------------------------------
// fdl_in_if
// Input channel of the fractional delay line: operation, sample and delay.
// ----------------------------------------------------------------------------
interface fdl_in_if
  import fdl_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  sample_t              sample;
  delay_t               delay;

  modport source (output valid, func, sample, delay, input ready);
  modport sink   (input valid, func, sample, delay, output ready);
endinterface

### rtl/fdl_out_if.sv
// ----------------------------------------------------------------------------
// fdl_out_if
// Result channel of the fractional delay line.
// ----------------------------------------------------------------------------
interface fdl_out_if
  import fdl_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t delayed;

  modport source (output valid, delayed, input ready);
  modport sink   (input valid, delayed, output ready);
endinterface

### rtl/fdl_cfg_if.sv
// ----------------------------------------------------------------------------
// fdl_cfg_if
// Register write channel of the fractional delay line.
// ----------------------------------------------------------------------------
interface fdl_cfg_if
  import fdl_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  delay_t                  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fdl_ram.sv
// ----------------------------------------------------------------------------
// fdl_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/fdl_lerp.sv
// ----------------------------------------------------------------------------
// fdl_lerp
// Linear interpolation between two samples by a fraction, rounded half up.
// ----------------------------------------------------------------------------
module fdl_lerp
  import fdl_pkg::*;
(
  input  sample_t newer,
  input  sample_t older,
  input  frac_t   frac,
  input  logic    zero,
  output sample_t result
);

  localparam int ACC_W = SAMPLE_BITS + FRAC_BITS + 3;

  logic signed [SAMPLE_BITS:0]             diff;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod;
  logic signed [ACC_W-1:0]                 acc;
  logic signed [ACC_W-1:0]                 shifted;

  always_comb begin
    diff    = $signed({older[SAMPLE_BITS-1], older}) - $signed({newer[SAMPLE_BITS-1], newer});
    prod    = diff * $signed({1'b0, frac});
    acc     = (ACC_W'(newer) <<< FRAC_BITS) + ACC_W'(prod)
              + $signed(ACC_W'(1) << (FRAC_BITS - 1));
    shifted = acc >>> FRAC_BITS;
    result  = zero ? '0 : shifted[SAMPLE_BITS-1:0];
  end

endmodule

### rtl/fractional_delay_line.sv
// ----------------------------------------------------------------------------
// fractional_delay_line
// Ring-buffer audio delay with linear interpolation between stored samples.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless the history clear or
// a stalled result holds in_if.ready low. The history memory is read at the
// acceptance edge, and one multiply of the interpolation sits between the read
// register and the result register. After reset the history memory is cleared
// one entry per cycle, and no input transaction is accepted until every entry
// has been cleared; register writes are taken at any time.
module fractional_delay_line
  import fdl_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  fdl_in_if.sink    in_if,
  fdl_out_if.source out_if,
  fdl_cfg_if.sink   cfg_if
);

  delay_t  dset_r, dset_nxt;
  delay_t  dmax_r, dmax_nxt;
  addr_t   wp_r, wp_nxt;
  addr_t   clr_addr_r, clr_addr_nxt;
  logic    clr_busy_r, clr_busy_nxt;
  logic    s1_valid_r, s1_valid_nxt;
  rd_ctl_t s1_r, s1_nxt;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_data_r, out_data_nxt;

  logic                         accept;
  logic                         s1_adv;
  delay_t                       eff_cfg;
  delay_t                       eff_in;
  delay_t                       rd_delay;
  logic                         wr;
  logic                         cur_newer;
  rd_ctl_t                      ctl;
  logic [WHOLE_BITS+ADDR_BITS-1:0] whole_ext;
  addr_t                        newer_addr;
  addr_t                        older_addr;
  logic                         ram_we;
  addr_t                        ram_waddr;
  sample_t                      ram_wdata;
  sample_t                      rd_newer;
  sample_t                      rd_older;
  sample_t                      lerp_newer;
  sample_t                      lerp_older;
  sample_t                      lerp_result;

  assign s1_adv       = !out_valid_r || out_if.ready;
  assign in_if.ready  = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.delayed = out_data_r;

  always_comb begin
    eff_cfg   = (dset_r < dmax_r) ? dset_r : dmax_r;
    eff_in    = (in_if.delay < dmax_r) ? in_if.delay : dmax_r;
    rd_delay  = eff_cfg;
    wr        = 1'b0;
    cur_newer = 1'b0;
    ctl       = '0;
    case (in_if.func)
      FUNC_PROCESS: begin
        wr             = 1'b1;
        ctl.has_result = 1'b1;
      end
      FUNC_PUSH: begin
        wr = 1'b1;
      end
      FUNC_READ_CFG: begin
        ctl.has_result = 1'b1;
        ctl.zero       = eff_cfg < ONE_SAMPLE;
      end
      FUNC_READ_FB: begin
        ctl.has_result = 1'b1;
        ctl.zero       = dmax_r < ONE_SAMPLE;
        rd_delay       = (eff_in < ONE_SAMPLE) ? ONE_SAMPLE : eff_in;
      end
      FUNC_READ_CUR: begin
        ctl.has_result = 1'b1;
        rd_delay       = eff_in;
        cur_newer      = eff_in < ONE_SAMPLE;
      end
      default: begin
        ctl.has_result = 1'b0;
      end
    endcase
    whole_ext      = {{ADDR_BITS{1'b0}}, rd_delay[DELAY_BITS-1:FRAC_BITS]};
    newer_addr     = wp_r - whole_ext[ADDR_BITS-1:0];
    older_addr     = newer_addr - ADDR_BITS'(1);
    ctl.newer_smp  = cur_newer || (wr && (newer_addr == wp_r));
    ctl.older_smp  = wr && (older_addr == wp_r);
    ctl.sample     = in_if.sample;
    ctl.frac       = rd_delay[FRAC_BITS-1:0];
  end

  always_comb begin
    ram_we    = clr_busy_r || (accept && wr);
    ram_waddr = clr_busy_r ? clr_addr_r : wp_r;
    ram_wdata = clr_busy_r ? '0 : in_if.sample;
  end

  fdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_history (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (newer_addr),
    .raddr_b (older_addr),
    .rdata_a (rd_newer),
    .rdata_b (rd_older)
  );

  assign lerp_newer = s1_r.newer_smp ? s1_r.sample : rd_newer;
  assign lerp_older = s1_r.older_smp ? s1_r.sample : rd_older;

  fdl_lerp u_lerp (
    .newer  (lerp_newer),
    .older  (lerp_older),
    .frac   (s1_r.frac),
    .zero   (s1_r.zero),
    .result (lerp_result)
  );

  always_comb begin
    dset_nxt      = dset_r;
    dmax_nxt      = dmax_r;
    wp_nxt        = wp_r;
    clr_addr_nxt  = clr_addr_r;
    clr_busy_nxt  = clr_busy_r;
    s1_valid_nxt  = s1_valid_r;
    s1_nxt        = s1_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_DELAY_SETTING: dset_nxt = cfg_if.data;
        CFG_MAX_DELAY:     dmax_nxt = cfg_if.data;
        default:           dset_nxt = dset_r;
      endcase
    end

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_BITS'(1);
      if (clr_addr_r == ADDR_BITS'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (accept && wr) begin
      wp_nxt = wp_r + ADDR_BITS'(1);
    end

    if (!s1_valid_r || s1_adv) begin
      s1_valid_nxt = accept;
      if (accept) begin
        s1_nxt = ctl;
      end
    end

    if (s1_adv) begin
      out_valid_nxt = s1_valid_r && s1_r.has_result;
      if (s1_valid_r && s1_r.has_result) begin
        out_data_nxt = lerp_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dset_r      <= '0;
      dmax_r      <= MAX_DELAY_RST;
      wp_r        <= '0;
      clr_addr_r  <= '0;
      clr_busy_r  <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dset_r      <= dset_nxt;
      dmax_r      <= dmax_nxt;
      wp_r        <= wp_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_busy_r  <= clr_busy_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_if.ready)
    else $error("input transaction accepted during history clear");

  a_s1_holds_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("read stage lost its transaction while the result was stalled");

  a_wp_only_on_write : assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && wr) |=> $stable(wp_r))
    else $error("write pointer moved without a write transaction");
`endif

endmodule
